// ----- src/sgme_pkg.sv -----
`timescale 1ns / 1ps

package sgme_pkg;

  localparam int MAX_GP = 1024;
  localparam int GP_W = 10;
  localparam int MAX_DIMS = 16;
  localparam int DIM_W = 4;
  localparam int MAX_LEVEL = 16;

  localparam logic [2:0] FUNC_LOAD_LI = 3'd0;
  localparam logic [2:0] FUNC_LOAD_W = 3'd1;
  localparam logic [2:0] FUNC_COORD = 3'd2;
  localparam logic [2:0] FUNC_READ = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [1:0] CFG_DIMS = 2'd0;
  localparam logic [1:0] CFG_POINTS = 2'd1;
  localparam logic [1:0] CFG_MODE = 2'd2;

  typedef struct packed {
    logic wr_in;
    logic rd_pt;
    logic ld_start;
    logic rd_dim;
    logic fac;
    logic mlo;
    logic mhi;
    logic cmb;
    logic clr_sum;
    logic add_pt;
    logic clr_wr;
    logic out_eval;
    logic out_read;
    logic mode;
    logic [GP_W-1:0] g;
    logic [DIM_W-1:0] d;
  } sgme_cmd_t;

  typedef struct packed {
    logic out_free;
  } sgme_stat_t;

endpackage

// ----- src/sparse_grid_modlinear_eval.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// input    | in_valid, in_stall     | func, grid_point, dim, level, index_value,
//          |                        | weight, coordinate, source_value, last_dim
// output   | out_valid, out_stall   | value, grid_point_out, overflow
// config   | cfg_write              | cfg_index, cfg_data
// A final coordinate walks the configured grid points, up to 1024, dim by dim.
// All 1024 accumulators are cleared after reset and on command.
// The input stalls while a walk, read, clear or result emission is in progress.
// A finished word waits in the output register while the input is open.

module sparse_grid_modlinear_eval import sgme_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic [9:0]         grid_point,
  input  logic [3:0]         dim,
  input  logic [4:0]         level,
  input  logic [15:0]        index_value,
  input  logic signed [31:0] weight,
  input  logic [31:0]        coordinate,
  input  logic signed [31:0] source_value,
  input  logic               last_dim,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] value,
  output logic [9:0]         grid_point_out,
  output logic               overflow,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  sgme_cmd_t  cmd;
  sgme_stat_t stat;

  sgme_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .grid_point(grid_point), .last_dim(last_dim),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .cmd(cmd)
  );

  sgme_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .func(func), .grid_point(grid_point),
    .dim(dim), .level(level), .index_value(index_value), .weight(weight),
    .coordinate(coordinate), .source_value(source_value),
    .out_valid(out_valid), .out_stall(out_stall), .value(value),
    .grid_point_out(grid_point_out), .overflow(overflow), .stat(stat)
  );

endmodule

// ----- src/sgme_ctrl.sv -----
`timescale 1ns / 1ps

module sgme_ctrl import sgme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [9:0]  grid_point,
  input  logic        last_dim,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  sgme_stat_t  stat,
  output sgme_cmd_t   cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PT     = 4'd2;
  localparam logic [3:0] S_LD     = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_FAC    = 4'd5;
  localparam logic [3:0] S_MLO    = 4'd6;
  localparam logic [3:0] S_MHI    = 4'd7;
  localparam logic [3:0] S_CMB    = 4'd8;
  localparam logic [3:0] S_ADD    = 4'd9;
  localparam logic [3:0] S_RDA    = 4'd10;
  localparam logic [3:0] S_EMIT_E = 4'd11;
  localparam logic [3:0] S_EMIT_R = 4'd12;

  logic [3:0]    state;
  logic [GP_W:0] g;
  logic [DIM_W:0] d;
  logic [4:0]    dims;
  logic [10:0]   pts;
  logic          mode;
  logic [4:0]    dims_eff;
  logic [10:0]   pts_eff;
  logic          accept;

  assign dims_eff = (dims > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : dims;
  assign pts_eff = (pts > 11'(MAX_GP)) ? 11'(MAX_GP) : pts;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= 5'd1;
      pts <= 11'd1;
      mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIMS: dims <= cfg_data[4:0];
        CFG_POINTS: pts <= cfg_data;
        CFG_MODE: mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      g <= '0;
      d <= '0;
    end else begin
      case (state)
        S_CLR: begin
          if (g == (GP_W+1)'(MAX_GP - 1)) begin
            state <= S_IDLE;
            g <= '0;
          end else begin
            g <= g + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (func)
              FUNC_COORD: begin
                g <= '0;
                if (last_dim) begin
                  if (pts_eff != 11'd0) state <= S_PT;
                  else if (!mode) state <= S_EMIT_E;
                end
              end
              FUNC_READ: begin
                g <= {1'b0, grid_point};
                state <= S_RDA;
              end
              FUNC_CLEAR: begin
                g <= '0;
                state <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_PT: state <= S_LD;
        S_LD: begin
          d <= '0;
          state <= (dims_eff == 5'd0) ? S_ADD : S_RD;
        end
        S_RD: state <= S_FAC;
        S_FAC: state <= S_MLO;
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_CMB;
        S_CMB: begin
          d <= d + 1'b1;
          state <= (d + 1'b1 == dims_eff) ? S_ADD : S_RD;
        end
        S_ADD: begin
          g <= g + 1'b1;
          if (g + 1'b1 == pts_eff) state <= mode ? S_IDLE : S_EMIT_E;
          else state <= S_PT;
        end
        S_RDA: state <= S_EMIT_R;
        S_EMIT_E: if (stat.out_free) state <= S_IDLE;
        S_EMIT_R: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.wr_in = accept;
    cmd.clr_sum = accept;
    cmd.mode = mode;
    cmd.g = g[GP_W-1:0];
    cmd.d = d[DIM_W-1:0];
    cmd.clr_wr = (state == S_CLR);
    cmd.rd_pt = (state == S_PT) || (state == S_RDA);
    cmd.ld_start = (state == S_LD);
    cmd.rd_dim = (state == S_RD);
    cmd.fac = (state == S_FAC);
    cmd.mlo = (state == S_MLO);
    cmd.mhi = (state == S_MHI);
    cmd.cmb = (state == S_CMB);
    cmd.add_pt = (state == S_ADD);
    cmd.out_eval = (state == S_EMIT_E) && stat.out_free;
    cmd.out_read = (state == S_EMIT_R) && stat.out_free;
  end

endmodule

// ----- src/sgme_dp.sv -----
`timescale 1ns / 1ps

module sgme_dp import sgme_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  sgme_cmd_t          cmd,
  input  logic [2:0]         func,
  input  logic [9:0]         grid_point,
  input  logic [3:0]         dim,
  input  logic [4:0]         level,
  input  logic [15:0]        index_value,
  input  logic signed [31:0] weight,
  input  logic [31:0]        coordinate,
  input  logic signed [31:0] source_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] value,
  output logic [9:0]         grid_point_out,
  output logic               overflow,
  output sgme_stat_t         stat
);

  logic [4:0]  lvl_mem [MAX_GP*MAX_DIMS];
  logic [15:0] idx_mem [MAX_GP*MAX_DIMS];
  logic [31:0] w_mem [MAX_GP];
  logic [47:0] acc_mem [MAX_GP];
  logic        aovf_mem [MAX_GP];
  logic [31:0] coord [MAX_DIMS];

  logic [31:0] src;
  logic [31:0] w_rd;
  logic [47:0] acc_rd;
  logic        aovf_rd;
  logic [4:0]  lvl_rd;
  logic [15:0] idx_rd;
  logic [31:0] x_rd;
  logic        neg;
  logic [47:0] m;
  logic        povf;
  logic [33:0] f;
  logic [57:0] lo;
  logic [57:0] hi;
  logic [47:0] sum;
  logic        sum_ovf;

  logic [31:0] start;
  logic [47:0] start_ext;
  logic [4:0]  lev_c;
  logic [47:0] t;
  logic [47:0] ish;
  logic [16:0] top;
  logic [48:0] tp;
  logic [47:0] dd;
  logic [33:0] f_next;
  logic [59:0] bsum;
  logic [50:0] mn;
  logic [47:0] lim;
  logic [48:0] pv;
  logic [48:0] p;
  logic [49:0] s_sum;
  logic [49:0] s_acc;
  logic [47:0] sum_next;
  logic        sum_sat;
  logic [47:0] acc_next;
  logic        acc_sat;

  function automatic logic level_gt(input logic [4:0] l);
    level_gt = (l > 5'(MAX_LEVEL));
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.wr_in) begin
      case (func)
        FUNC_LOAD_LI: begin
          lvl_mem[{grid_point, dim}] <= level;
          idx_mem[{grid_point, dim}] <= index_value;
        end
        FUNC_LOAD_W: w_mem[grid_point] <= weight;
        FUNC_COORD: begin
          coord[dim] <= coordinate;
          src <= source_value;
        end
        default: ;
      endcase
    end
    if (cmd.rd_dim) begin
      lvl_rd <= lvl_mem[{cmd.g, cmd.d}];
      idx_rd <= idx_mem[{cmd.g, cmd.d}];
      x_rd <= coord[cmd.d];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_pt) begin
      w_rd <= w_mem[cmd.g];
      acc_rd <= acc_mem[cmd.g];
      aovf_rd <= aovf_mem[cmd.g];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      acc_mem[cmd.g] <= '0;
      aovf_mem[cmd.g] <= 1'b0;
    end else if (cmd.add_pt && cmd.mode) begin
      acc_mem[cmd.g] <= acc_next;
      aovf_mem[cmd.g] <= aovf_rd | povf | acc_sat;
    end
  end

  always_comb begin
    start = cmd.mode ? src : w_rd;
    start_ext = {{16{start[31]}}, start};

    lev_c = (level_gt(lvl_rd)) ? 5'(MAX_LEVEL) : lvl_rd;
    t = {16'b0, x_rd} << lev_c;
    ish = {idx_rd, 32'b0};
    top = (17'd1 << lev_c) - 17'd1;
    tp = {1'b0, t} + 49'h1_0000_0000;
    dd = (t >= ish) ? (t - ish) : (ish - t);
    if (lev_c == 5'd1) begin
      f_next = 34'h1_0000_0000;
    end else if (idx_rd == 16'd1) begin
      f_next = (t < 48'h2_0000_0000) ? 34'(48'h2_0000_0000 - t) : 34'd0;
    end else if ({1'b0, idx_rd} == top) begin
      f_next = (tp > {1'b0, ish}) ? 34'(tp - {1'b0, ish}) : 34'd0;
    end else begin
      f_next = (dd < 48'h1_0000_0000) ? 34'(48'h1_0000_0000 - dd) : 34'd0;
    end

    bsum = 60'({hi[7:0], 24'b0}) + 60'(lo);
    mn = 51'(hi[57:8]) + 51'(bsum[59:32]);
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;

    pv = {1'b0, m};
    p = neg ? (~pv + 49'd1) : pv;

    s_sum = {{2{sum[47]}}, sum} + {p[48], p};
    sum_sat = (s_sum[49:47] != 3'b000) && (s_sum[49:47] != 3'b111);
    sum_next = !sum_sat ? s_sum[47:0] :
               (s_sum[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);

    s_acc = {{2{acc_rd[47]}}, acc_rd} + {p[48], p};
    acc_sat = (s_acc[49:47] != 3'b000) && (s_acc[49:47] != 3'b111);
    acc_next = !acc_sat ? s_acc[47:0] :
               (s_acc[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_start) begin
      neg <= start[31];
      m <= start[31] ? (~start_ext + 48'd1) : start_ext;
      povf <= 1'b0;
    end else if (cmd.cmb) begin
      if (mn > {3'b0, lim}) begin
        m <= lim;
        povf <= 1'b1;
      end else begin
        m <= mn[47:0];
      end
    end
    if (cmd.fac) f <= f_next;
    if (cmd.mlo) lo <= 58'(m[23:0]) * 58'(f);
    if (cmd.mhi) hi <= 58'(m[47:24]) * 58'(f);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_sum) begin
      sum <= '0;
      sum_ovf <= 1'b0;
    end else if (cmd.add_pt && !cmd.mode) begin
      sum <= sum_next;
      sum_ovf <= sum_ovf | povf | sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_eval || cmd.out_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_eval) begin
      value <= sum;
      grid_point_out <= '0;
      overflow <= sum_ovf;
    end else if (cmd.out_read) begin
      value <= acc_rd;
      grid_point_out <= cmd.g;
      overflow <= aovf_rd;
    end
  end

  assign stat.out_free = !out_valid || !out_stall;

endmodule
